FILE: design/hsfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsfp_pkg;

  localparam int COUNT_BITS  = 20;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_W     = $clog2(PHASE_COUNT);

  localparam int SPF_W   = 12;
  localparam int FLOOR_W = 8;
  localparam int CNT_IN_W = 20;
  localparam int COIL_W  = 4;
  localparam int CFG_W   = 12;
  localparam int CFG_A_W = 1;

  // Floor difference times steps per floor, and the width to compare it in.
  localparam int PROD_W = FLOOR_W + SPF_W;
  localparam int WIDE_W = (COUNT_BITS > PROD_W) ? COUNT_BITS : PROD_W;
  localparam int CIN_WIDE_W = (COUNT_BITS > CNT_IN_W) ? COUNT_BITS : CNT_IN_W;

  localparam logic [SPF_W-1:0]   SPF_RST       = SPF_W'(512);
  localparam logic [FLOOR_W-1:0] TOP_FLOOR_RST = FLOOR_W'(5);
  localparam logic [FLOOR_W-1:0] FLOOR_FIRST   = FLOOR_W'(1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_STEP  = 2'd1,
    OP_FLOOR = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_FLOOR_SPAN = 1'b0,
    REG_TOP_FLOOR  = 1'b1
  } cfg_reg_t;

  // Half-step coil patterns, bit0 drives the first coil.
  function automatic logic [COIL_W-1:0] coil_lookup(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    begin
      unique case (ph)
        3'd0:    pat = 4'h1;
        3'd1:    pat = 4'h3;
        3'd2:    pat = 4'h2;
        3'd3:    pat = 4'h6;
        3'd4:    pat = 4'h4;
        3'd5:    pat = 4'hC;
        3'd6:    pat = 4'h8;
        default: pat = 4'h9;
      endcase
      return pat;
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/half_step_floor_positioner.sv
`timescale 1ns / 1ps
`default_nettype none
// Half-step floor positioner: sequences a four-coil unipolar stepper through
// the eight-phase half-step pattern to carry a car between floors.
// Input channel (in_valid / in_stall): one request per event - a tick (one
// step period), a move by a step count, a move to a floor, or a stop.
// Result channel (out_valid / out_stall): exactly one result per request,
// carrying the coil drive, the busy flag and the current and target floors.
// Throughput: one request per cycle while out_stall is low; a request passes
// from the input register to the motor state register (which doubles as the
// result register and drives the result channel). These form the two stages,
// with the whole event decode, the 8x12 floor-distance multiply and the count
// saturation between them.
// Stall: while out_stall holds a result, the state does not advance; the
// input register still takes one request, then in_stall rises.
// Reset (rst_n low, synchronous): coils off, phase 0, idle, car and target
// at floor 1, floor span 512 half steps, top_floor 5, both channels empty.
// Configuration (cfg_we / cfg_addr / cfg_wdata): the user writes it while idle only; the block does not enforce it.
module half_step_floor_positioner
  import hsfp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_operation,
  input  wire logic [CNT_IN_W-1:0] in_step_count,
  input  wire logic                in_move_down,
  input  wire logic [FLOOR_W-1:0]  in_floor_request,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [COIL_W-1:0]        out_coil_pattern,
  output logic                     out_busy_res,
  output logic [FLOOR_W-1:0]       out_floor_now,
  output logic [FLOOR_W-1:0]       out_floor_goal,

  input  wire logic                cfg_we,
  input  wire logic [CFG_A_W-1:0]  cfg_addr,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  // configuration registers
  logic [SPF_W-1:0]   spf_r;
  logic [FLOOR_W-1:0] top_floor_r;

  // input stage
  logic                in_vld_r;
  op_t                 op_r;
  logic [CNT_IN_W-1:0] cnt_r;
  logic                down_r;
  logic [FLOOR_W-1:0]  flr_r;

  // motor state; the visible part doubles as the result register
  logic                  out_vld_r;
  logic [PHASE_W-1:0]    phase_r,      phase_nxt;
  logic [COUNT_BITS-1:0] steps_left_r, steps_left_nxt;
  logic                  going_down_r, going_down_nxt;
  logic                  moving_r,     moving_nxt;
  logic [FLOOR_W-1:0]    floor_at_r,   floor_at_nxt;
  logic [FLOOR_W-1:0]    target_r,     target_nxt;
  logic [COIL_W-1:0]     coils_r,      coils_nxt;

  logic                  adv;
  logic                  fire;
  logic                  in_take;
  logic                  floor_ok;
  logic                  floor_up;
  logic [FLOOR_W-1:0]    floor_diff;
  logic [WIDE_W-1:0]     floor_prod;
  logic [COUNT_BITS-1:0] floor_cnt;
  logic [CIN_WIDE_W-1:0] step_wide;
  logic [COUNT_BITS-1:0] step_cnt;
  logic [PHASE_W-1:0]    phase_step;

  // Advance the state whenever the result slot is free or being taken.
  assign adv      = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spf_r       <= SPF_RST;
      top_floor_r <= TOP_FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FLOOR_SPAN: spf_r       <= cfg_wdata[SPF_W-1:0];
        REG_TOP_FLOOR:  top_floor_r <= cfg_wdata[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= op_t'(in_operation);
      cnt_r  <= in_step_count;
      down_r <= in_move_down;
      flr_r  <= in_floor_request;
    end
  end

  // Floor move: distance times steps per floor, clamped to the counter.
  assign floor_up   = flr_r > floor_at_r;
  assign floor_diff = floor_up ? (flr_r - floor_at_r) : (floor_at_r - flr_r);
  assign floor_prod = WIDE_W'(floor_diff) * WIDE_W'(spf_r);
  assign floor_cnt  = (floor_prod > WIDE_W'({COUNT_BITS{1'b1}})) ?
                      {COUNT_BITS{1'b1}} : floor_prod[COUNT_BITS-1:0];
  assign floor_ok   = (flr_r >= FLOOR_FIRST) && (flr_r <= top_floor_r) &&
                      !moving_r && (flr_r != floor_at_r);

  assign step_wide  = CIN_WIDE_W'(cnt_r);
  assign step_cnt   = (step_wide > CIN_WIDE_W'({COUNT_BITS{1'b1}})) ?
                      {COUNT_BITS{1'b1}} : step_wide[COUNT_BITS-1:0];

  // Wrap the phase forward going up, back going down.
  always_comb begin
    if (going_down_r) begin
      phase_step = (phase_r == '0) ? PHASE_W'(PHASE_COUNT - 1) : phase_r - 1'b1;
    end else begin
      phase_step = (phase_r == PHASE_W'(PHASE_COUNT - 1)) ? '0 : phase_r + 1'b1;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    steps_left_nxt = steps_left_r;
    going_down_nxt = going_down_r;
    moving_nxt     = moving_r;
    floor_at_nxt   = floor_at_r;
    target_nxt     = target_r;
    coils_nxt      = coils_r;
    unique case (op_r)
      OP_TICK: begin
        if (moving_r) begin
          if (steps_left_r != '0) begin
            phase_nxt      = phase_step;
            coils_nxt      = coil_lookup(phase_step);
            steps_left_nxt = steps_left_r - 1'b1;
          end else begin
            // count ran out: release the coils and arrive
            coils_nxt    = '0;
            floor_at_nxt = target_r;
            moving_nxt   = 1'b0;
          end
        end
      end
      OP_STEP: begin
        if (!moving_r && (step_cnt != '0)) begin
          steps_left_nxt = step_cnt;
          going_down_nxt = down_r;
          moving_nxt     = 1'b1;
        end
      end
      OP_FLOOR: begin
        if (floor_ok) begin
          // target sticks even when the loaded count is zero
          target_nxt = flr_r;
          if (floor_cnt != '0) begin
            steps_left_nxt = floor_cnt;
            going_down_nxt = !floor_up;
            moving_nxt     = 1'b1;
          end
        end
      end
      OP_STOP: begin
        steps_left_nxt = '0;
        moving_nxt     = 1'b0;
        coils_nxt      = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r    <= 1'b0;
      phase_r      <= '0;
      steps_left_r <= '0;
      going_down_r <= 1'b0;
      moving_r     <= 1'b0;
      floor_at_r   <= FLOOR_FIRST;
      target_r     <= FLOOR_FIRST;
      coils_r      <= '0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
      if (fire) begin
        phase_r      <= phase_nxt;
        steps_left_r <= steps_left_nxt;
        going_down_r <= going_down_nxt;
        moving_r     <= moving_nxt;
        floor_at_r   <= floor_at_nxt;
        target_r     <= target_nxt;
        coils_r      <= coils_nxt;
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_coil_pattern = coils_r;
  assign out_busy_res     = moving_r;
  assign out_floor_now    = floor_at_r;
  assign out_floor_goal   = target_r;

`ifndef SYNTH
  // Coils are only energized during a move.
  a_idle_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
    !moving_r |-> (coils_r == '0))
    else $error("coils driven while idle");

  // An idle motor holds no pending steps.
  a_idle_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
    !moving_r |-> (steps_left_r == '0))
    else $error("steps pending while idle");

  // Only a tick may move the phase.
  a_phase_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (op_r != OP_TICK)) |=> $stable(phase_r))
    else $error("phase moved on a command");

  // An empty input stage never back-pressures.
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> !in_stall)
    else $error("stall with empty input stage");
`endif

endmodule

`default_nettype wire
